// ===== sv/sfm_pkg.sv =====
// Package for the single-precision multiplier: float encodings and helper types.
// No dependencies.
`default_nettype none
package sfm_pkg;
   localparam int ExpW  = 8;
   localparam int FracW = 23;
   localparam int SigW  = FracW + 1;
   localparam int ProdW = 2 * SigW;

   localparam logic [31:0] QnanWord   = 32'h7FC0_0000;
   localparam logic [31:0] PosInfWord = 32'h7F80_0000;
   localparam logic [ExpW-1:0] ExpMax = 8'hFF;
   localparam logic [ExpW-1:0] Bias   = 8'h7F;

   // special-case classification, decided combinationally in sfm_core from the registered operands
   typedef enum logic [3:0] {
      CLS_NORMAL = 4'b0001,
      CLS_NAN    = 4'b0010,
      CLS_INF    = 4'b0100,
      CLS_ZERO   = 4'b1000
   } class_type;
endpackage
`default_nettype wire

// ===== sv/sfm_core.sv =====
// Combinational datapath: classify operands, multiply significands,
// normalize by one place, truncate, and assemble. Depends on sfm_pkg.
`default_nettype none
module sfm_core (
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic [31:0]      p
);
   import sfm_pkg::*;

   logic [ExpW-1:0]  ea, eb;
   logic             nan_a, nan_b;
   class_type        cls;
   logic [ProdW-1:0] sig;
   logic             top;
   logic [FracW-1:0] frac;
   logic signed [ExpW+2:0] e;
   logic             sign;

   always_comb begin
      ea    = a[30:23];
      eb    = b[30:23];
      nan_a = (ea == ExpMax) && (a[FracW-1:0] != '0);
      nan_b = (eb == ExpMax) && (b[FracW-1:0] != '0);
      if (nan_a || nan_b)                 cls = CLS_NAN;
      else if (ea == ExpMax || eb == ExpMax) cls = CLS_INF;
      else if (ea == '0 || eb == '0)      cls = CLS_ZERO;
      else                                cls = CLS_NORMAL;

      sig  = {1'b1, a[FracW-1:0]} * {1'b1, b[FracW-1:0]};
      top  = sig[ProdW-1];
      frac = top ? sig[ProdW-2 -: FracW] : sig[ProdW-3 -: FracW];
      e    = $signed({3'b000, ea}) + $signed({3'b000, eb})
             - $signed({3'b000, Bias}) + $signed({10'd0, top});
      sign = a[31] ^ b[31];

      case (cls)
         CLS_NAN:  p = QnanWord;
         CLS_INF:  p = PosInfWord;
         CLS_ZERO: p = '0;
         CLS_NORMAL: begin
            if (e >= 11'sd255)    p = {sign, PosInfWord[30:0]};
            else if (e <= 11'sd0) p = '0;
            else                  p = {sign, e[ExpW-1:0], frac};
         end
         default:  p = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/single_float_multiplier.sv =====
// Truncating IEEE 754 single-precision multiplier.
// An accepted req beat passes the input register, then the result register, to
// rsp_valid. Throughput: one beat per cycle while rsp_stall is low; both registers advance
// together whenever the result beat leaves, and a result stall reaches req_stall directly.
// Reset (synchronous, active high) clears both valid flags; payload is not reset.
// Depends on sfm_pkg and sfm_core.
`default_nettype none
module single_float_multiplier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_multiplicand,
   input  wire logic [31:0] req_multiplier,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_product
);
   import sfm_pkg::*;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [31:0] a_ff, b_ff;
   // result stage
   logic        out_valid_ff, out_valid_in;
   logic [31:0] p_ff;
   logic [31:0] p_in;
   logic        adv_out, adv_in;

   sfm_core u_core (.a(a_ff), .b(b_ff), .p(p_in));

   // advance the result register when it is empty or its beat leaves now
   assign adv_out = !out_valid_ff || !rsp_stall;
   // advance the input register when its beat can move on
   assign adv_in  = !in_valid_ff || adv_out;
   assign req_stall = !adv_in;

   always_comb begin
      in_valid_in  = adv_in  ? req_valid   : in_valid_ff;
      out_valid_in = adv_out ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (adv_in && req_valid) begin
         a_ff <= req_multiplicand;
         b_ff <= req_multiplier;
      end
      // hold the result while stalled
      if (adv_out && in_valid_ff) p_ff <= p_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_product = p_ff;
endmodule
`default_nettype wire

// ===== sv/sfm_checker.sv =====
// Port-level checks for single_float_multiplier, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module sfm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_product
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product))
      else $error("rsp beat changed under stall");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty result stage");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not arrive in two cycles");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");
endmodule

bind single_float_multiplier sfm_checker u_sfm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_product(rsp_product)
);
`default_nettype wire
